[rtl/core/rvt_pkg.sv]
`default_nettype none
package rvt_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_DIM     = 16;
    localparam int MAX_RES     = 3 * MAX_DIM - 2;
    localparam int DIM_W       = 5;
    localparam int CNT_W       = $clog2(MAX_RES + 1);
    localparam int IDX_W       = 12;
    localparam int IDX_FULL_W  = 3 * DIM_W;
    localparam int PLANE_W     = 40;
    localparam int NUM_W       = 64;
    localparam int DEN_W       = 33;
    localparam int DIV_CNT_W   = $clog2(NUM_W + 1);
    localparam int CFG_IDX_W   = 3;

    localparam logic signed [31:0] T_HUGE = 32'sh7fff_ffff;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 3'd6;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_PLANE_A,
        OP_PLANE_B,
        OP_DIV_T,
        OP_STORE_TL,
        OP_CLIP,
        OP_MUL,
        OP_ENT,
        OP_DIV_CELL,
        OP_CELL,
        OP_DIV_DELTA,
        OP_DELTA,
        OP_PLANE_N,
        OP_NEXT,
        OP_ZERO,
        OP_WALK_INIT,
        OP_WALK
    } dp_op_t;

    typedef struct packed {
        dp_op_t      op;
        logic [1:0]  axis;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic dir_zero;
        logic miss;
        logic walk_active;
    } dp_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7fff_ffff)
            r = 32'sh7fff_ffff;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/ray_voxel_traversal_core.sv]
// Channel   Direction  Transaction
// s_axis    in         one ray: tdata = pos_x/y/z, dir_x/y/z, step_length
// m_axis    out        one voxel crossing: tdata = voxel_index, seg_len;
//                      tuser = hit, tlast = last crossing of the ray
// cfg       in         register write, one per cycle, no read-back
//
// One ray at a time. Setup runs up to 15 divisions on a shared 64-step
// divider, then the walk emits one result per cycle.
// rst_n resets the controller and output valid flag, and loads the configuration defaults.
// A stalled m_axis holds the walk; the result register frees the datapath.
`default_nettype none
module ray_voxel_traversal_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [127:96] dir_x,
    // [159:128] dir_y, [191:160] dir_z, [222:192] step_length
    input  wire logic [223:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [11:0] voxel_index, [42:12] seg_len
    output logic [47:0]        m_axis_tdata,
    // [0] hit
    output logic [0:0]         m_axis_tuser,
    output logic               m_axis_tlast,
    input  wire logic          cfg_wr_en,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    rvt_pkg::dp_cmd_t     cmd;
    rvt_pkg::dp_status_t  status;
    logic                 in_fire;
    logic [rvt_pkg::IDX_W-1:0] out_index;
    logic [30:0]          out_len;
    logic                 out_hit;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    rvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .status   (status),
        .cmd      (cmd),
        .in_ready (s_axis_tready)
    );

    rvt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_index (out_index),
        .out_len   (out_len),
        .out_hit   (out_hit),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, out_len, out_index};
    assign m_axis_tuser = out_hit;

endmodule
`default_nettype wire

[rtl/core/rvt_divider.sv]
`default_nettype none
module rvt_divider (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic signed [rvt_pkg::NUM_W-1:0]       num,
    input  wire logic signed [rvt_pkg::DEN_W-1:0]       den,
    output logic                                        done,
    output logic signed [rvt_pkg::NUM_W-1:0]            quot
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [rvt_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic [rvt_pkg::NUM_W-1:0]           dvd_reg;
    logic [31:0]                         rem_reg;
    logic [31:0]                         den_reg;
    logic                                neg_reg;
    logic signed [rvt_pkg::NUM_W-1:0]    quot_reg;

    logic [33:0]                         diff;
    logic [rvt_pkg::NUM_W-1:0]           dvd_next;
    logic [rvt_pkg::NUM_W-1:0]           num_mag;
    logic signed [rvt_pkg::DEN_W-1:0]    den_abs;

    always_comb
    begin
        diff     = {1'b0, rem_reg, dvd_reg[rvt_pkg::NUM_W-1]} - {2'b00, den_reg};
        dvd_next = {dvd_reg[rvt_pkg::NUM_W-2:0], ~diff[33]};
        num_mag  = num[rvt_pkg::NUM_W-1] ? rvt_pkg::NUM_W'(-num) : rvt_pkg::NUM_W'(num);
        den_abs  = den[rvt_pkg::DEN_W-1] ? -den : den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= rvt_pkg::DIV_CNT_W'(rvt_pkg::NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == rvt_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= num_mag;
            rem_reg <= '0;
            den_reg <= den_abs[31:0];
            neg_reg <= num[rvt_pkg::NUM_W-1] ^ den[rvt_pkg::DEN_W-1];
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            if (!diff[33])
                rem_reg <= diff[31:0];
            else
                rem_reg <= {rem_reg[30:0], dvd_reg[rvt_pkg::NUM_W-1]};
            if (cnt_reg == rvt_pkg::DIV_CNT_W'(1))
                quot_reg <= neg_reg ? -$signed(dvd_next) : $signed(dvd_next);
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

[rtl/core/rvt_datapath.sv]
`default_nettype none
module rvt_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [rvt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                       cfg_data,
    input  wire logic                              in_fire,
    input  wire logic [223:0]                      in_data,
    input  wire rvt_pkg::dp_cmd_t                  cmd,
    output rvt_pkg::dp_status_t                    status,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [rvt_pkg::IDX_W-1:0]              out_index,
    output logic [30:0]                            out_len,
    output logic                                   out_hit,
    output logic                                   out_last
);

    localparam int DW = rvt_pkg::DIM_W;

    logic signed [31:0]  origin_reg [3];
    logic [30:0]         spacing_reg [3];
    logic [14:0]         grid_reg;

    logic signed [31:0]  pos_reg [3];
    logic signed [31:0]  dir_reg [3];
    logic signed [31:0]  te_reg;
    logic signed [31:0]  tx_reg;
    logic                miss_reg;
    logic signed [rvt_pkg::PLANE_W-1:0] plane_reg;
    logic signed [rvt_pkg::PLANE_W-1:0] tmp_reg;
    logic signed [63:0]  prod_reg;
    logic signed [63:0]  d_reg;

    logic [DW-1:0]       coord_reg [3];
    logic signed [31:0]  nct_reg [3];
    logic signed [31:0]  dct_reg [3];
    logic [1:0]          step_reg [3];
    logic signed [31:0]  cur_reg;
    logic signed [31:0]  exit_reg;
    logic [rvt_pkg::CNT_W-1:0] cnt_reg;
    logic [2*DW-1:0]     n01_reg;
    logic                walk_active_reg;

    logic                out_valid_reg;
    logic [rvt_pkg::IDX_W-1:0] out_index_reg;
    logic [30:0]         out_len_reg;
    logic                out_hit_reg;
    logic                out_last_reg;

    logic [DW-1:0]       dim [3];
    logic [30:0]         spc [3];
    logic [1:0]          ax;
    logic signed [31:0]  p_s, v_s, o_s;
    logic [30:0]         sp_s;
    logic [DW-1:0]       n_s, c_s, k;
    logic                v_zero, v_neg;
    logic [DW+30:0]      ksp;
    logic signed [rvt_pkg::PLANE_W-1:0] plane_next;

    logic                div_start, div_done;
    logic signed [rvt_pkg::NUM_W-1:0] div_num, div_quot;
    logic signed [rvt_pkg::DEN_W-1:0] div_den;

    logic signed [31:0]  tl, th, te_n, tx_n;
    logic signed [63:0]  ent;
    logic [DW-1:0]       cell_c;

    logic                out_free, walk_go;
    logic [1:0]          sel;
    logic signed [31:0]  nsel, tn;
    logic signed [32:0]  pl_w;
    logic [30:0]         pl_sat;
    logic                fin, stop;
    logic [2:0]          tie, edge_hit;
    logic [rvt_pkg::IDX_FULL_W-1:0] idx_full;
    logic signed [31:0]  nct_add [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (grid_reg[DW*i +: DW] == '0)
                dim[i] = DW'(1);
            else if (grid_reg[DW*i +: DW] > DW'(rvt_pkg::MAX_DIM))
                dim[i] = DW'(rvt_pkg::MAX_DIM);
            else
                dim[i] = grid_reg[DW*i +: DW];
            spc[i] = (spacing_reg[i] == '0) ? 31'd1 : spacing_reg[i];
        end
    end

    always_comb
    begin
        ax     = cmd.axis;
        p_s    = pos_reg[ax];
        v_s    = dir_reg[ax];
        o_s    = origin_reg[ax];
        sp_s   = spc[ax];
        n_s    = dim[ax];
        c_s    = coord_reg[ax];
        v_zero = (v_s == '0);
        v_neg  = v_s[31];
        case (cmd.op)
            rvt_pkg::OP_PLANE_A: k = v_neg ? n_s : '0;
            rvt_pkg::OP_PLANE_B: k = v_neg ? '0 : n_s;
            rvt_pkg::OP_PLANE_N: k = v_neg ? c_s : c_s + 1'b1;
            default:             k = '0;
        endcase
        ksp        = (DW+31)'(k) * (DW+31)'(sp_s);
        plane_next = rvt_pkg::PLANE_W'(o_s) + $signed(rvt_pkg::PLANE_W'(ksp));

        div_start = 1'b0;
        div_num   = '0;
        div_den   = rvt_pkg::DEN_W'(v_s);
        case (cmd.op)
            rvt_pkg::OP_DIV_T:
            begin
                div_start = 1'b1;
                div_num   = (rvt_pkg::NUM_W'(plane_reg) - rvt_pkg::NUM_W'(p_s))
                            <<< rvt_pkg::FRAC_BITS;
                div_den   = rvt_pkg::DEN_W'(v_s);
            end
            rvt_pkg::OP_DIV_CELL:
            begin
                div_start = 1'b1;
                div_num   = d_reg[63] ? '0 : d_reg;
                div_den   = $signed({2'b00, sp_s});
            end
            rvt_pkg::OP_DIV_DELTA:
            begin
                div_start = 1'b1;
                div_num   = $signed(rvt_pkg::NUM_W'(sp_s)) <<< rvt_pkg::FRAC_BITS;
                div_den   = v_neg ? -rvt_pkg::DEN_W'(v_s) : rvt_pkg::DEN_W'(v_s);
            end
            default: ;
        endcase

        tl   = $signed(tmp_reg[31:0]);
        th   = rvt_pkg::sat32(div_quot);
        te_n = (tl > te_reg) ? tl : te_reg;
        tx_n = (th < tx_reg) ? th : tx_reg;

        ent = prod_reg[63]
            ? (prod_reg + ((64'sd1 <<< rvt_pkg::FRAC_BITS) - 64'sd1)) >>> rvt_pkg::FRAC_BITS
            : prod_reg >>> rvt_pkg::FRAC_BITS;

        if (div_quot >= $signed(64'(n_s)))
            cell_c = n_s - 1'b1;
        else
            cell_c = div_quot[DW-1:0];
    end

    rvt_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // walk step
    always_comb
    begin
        if (nct_reg[0] <= nct_reg[1] && nct_reg[0] <= nct_reg[2])
            sel = 2'd0;
        else if (nct_reg[1] <= nct_reg[2])
            sel = 2'd1;
        else
            sel = 2'd2;
        nsel = nct_reg[sel];
        tn   = (nsel < exit_reg) ? nsel : exit_reg;
        fin  = (tn >= exit_reg);
        pl_w = 33'(tn) - 33'(cur_reg);
        if (pl_w < 0)
            pl_sat = '0;
        else if (pl_w > 33'sh0_7fff_ffff)
            pl_sat = 31'h7fff_ffff;
        else
            pl_sat = pl_w[30:0];
        for (int i = 0; i < 3; i++)
        begin
            tie[i]      = (step_reg[i] != 2'b00) && (nct_reg[i] == tn) && !fin;
            edge_hit[i] = step_reg[i][1] ? (coord_reg[i] == '0)
                                         : (coord_reg[i] == dim[i] - 1'b1);
            nct_add[i]  = rvt_pkg::sat32(64'(nct_reg[i]) + 64'(dct_reg[i]));
        end
        stop     = |(tie & edge_hit);
        idx_full = rvt_pkg::IDX_FULL_W'(coord_reg[0])
                 + rvt_pkg::IDX_FULL_W'(dim[0]) * rvt_pkg::IDX_FULL_W'(coord_reg[1])
                 + rvt_pkg::IDX_FULL_W'(n01_reg) * rvt_pkg::IDX_FULL_W'(coord_reg[2]);
        out_free = !out_valid_reg || out_ready;
        walk_go  = (cmd.op == rvt_pkg::OP_WALK) && walk_active_reg && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                origin_reg[i]  <= '0;
                spacing_reg[i] <= 31'd65536;
            end
            grid_reg        <= 15'd16912;
            walk_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            miss_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    rvt_pkg::CFG_ORIGIN_X:  origin_reg[0]  <= cfg_data;
                    rvt_pkg::CFG_ORIGIN_Y:  origin_reg[1]  <= cfg_data;
                    rvt_pkg::CFG_ORIGIN_Z:  origin_reg[2]  <= cfg_data;
                    rvt_pkg::CFG_SPACING_X: spacing_reg[0] <= cfg_data[30:0];
                    rvt_pkg::CFG_SPACING_Y: spacing_reg[1] <= cfg_data[30:0];
                    rvt_pkg::CFG_SPACING_Z: spacing_reg[2] <= cfg_data[30:0];
                    rvt_pkg::CFG_GRID_SIZE: grid_reg       <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (in_fire)
                miss_reg <= 1'b0;
            else if (cmd.op == rvt_pkg::OP_CLIP)
            begin
                if (v_zero)
                begin
                    if (rvt_pkg::PLANE_W'(p_s) < tmp_reg || rvt_pkg::PLANE_W'(p_s) >= plane_reg)
                        miss_reg <= 1'b1;
                end
                else if (te_n >= tx_n)
                    miss_reg <= 1'b1;
            end
            if (cmd.op == rvt_pkg::OP_WALK_INIT)
                walk_active_reg <= 1'b1;
            else if (walk_go && (miss_reg || fin || stop ||
                     cnt_reg == rvt_pkg::CNT_W'(rvt_pkg::MAX_RES - 1)))
                walk_active_reg <= 1'b0;
            if (walk_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= in_data[32*i +: 32];
                dir_reg[i] <= in_data[96 + 32*i +: 32];
            end
            te_reg <= '0;
            tx_reg <= $signed({1'b0, in_data[222:192]});
        end
        case (cmd.op)
            rvt_pkg::OP_PLANE_A:  plane_reg <= plane_next;
            rvt_pkg::OP_PLANE_B:
            begin
                plane_reg <= plane_next;
                if (v_zero)
                    tmp_reg <= plane_reg;
            end
            rvt_pkg::OP_PLANE_N:  plane_reg <= plane_next;
            rvt_pkg::OP_STORE_TL: tmp_reg   <= rvt_pkg::PLANE_W'(th);
            rvt_pkg::OP_CLIP:
            begin
                if (!v_zero)
                begin
                    te_reg <= te_n;
                    tx_reg <= tx_n;
                end
            end
            rvt_pkg::OP_MUL:      prod_reg <= 64'(te_reg) * 64'(v_s);
            rvt_pkg::OP_ENT:      d_reg <= 64'(p_s) + ent - 64'(o_s);
            rvt_pkg::OP_CELL:     coord_reg[ax] <= cell_c;
            rvt_pkg::OP_DELTA:
            begin
                dct_reg[ax]  <= th;
                step_reg[ax] <= v_neg ? 2'b11 : 2'b01;
            end
            rvt_pkg::OP_NEXT:     nct_reg[ax] <= th;
            rvt_pkg::OP_ZERO:
            begin
                dct_reg[ax]  <= rvt_pkg::T_HUGE;
                nct_reg[ax]  <= rvt_pkg::T_HUGE;
                step_reg[ax] <= 2'b00;
            end
            rvt_pkg::OP_WALK_INIT:
            begin
                cur_reg  <= te_reg;
                exit_reg <= tx_reg;
                cnt_reg  <= '0;
                n01_reg  <= (2*DW)'(dim[0]) * (2*DW)'(dim[1]);
            end
            default: ;
        endcase
        if (walk_go)
        begin
            if (miss_reg)
            begin
                out_index_reg <= '0;
                out_len_reg   <= '0;
                out_hit_reg   <= 1'b0;
                out_last_reg  <= 1'b1;
            end
            else
            begin
                out_index_reg <= idx_full[rvt_pkg::IDX_W-1:0];
                out_len_reg   <= pl_sat;
                out_hit_reg   <= 1'b1;
                out_last_reg  <= fin || stop ||
                                 cnt_reg == rvt_pkg::CNT_W'(rvt_pkg::MAX_RES - 1);
                cur_reg       <= tn;
                cnt_reg       <= cnt_reg + 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    if (tie[i])
                    begin
                        nct_reg[i]   <= nct_add[i];
                        coord_reg[i] <= step_reg[i][1] ? coord_reg[i] - 1'b1
                                                       : coord_reg[i] + 1'b1;
                    end
                end
            end
        end
    end

    assign status.div_done    = div_done;
    assign status.dir_zero    = v_zero;
    assign status.miss        = miss_reg;
    assign status.walk_active = walk_active_reg;

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_len   = out_len_reg;
    assign out_hit   = out_hit_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

[rtl/core/rvt_ctrl.sv]
`default_nettype none
module rvt_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_fire,
    input  wire rvt_pkg::dp_status_t  status,
    output rvt_pkg::dp_cmd_t          cmd,
    output logic                      in_ready
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_PA, ST_DWA, ST_ST, ST_PB, ST_DWB, ST_CU, ST_CHK,
        ST_EM, ST_EE, ST_DWC, ST_CL, ST_DWD, ST_DL, ST_PN, ST_DWN,
        ST_AXE, ST_WI, ST_WK
    } state_t;

    state_t            state_reg;
    rvt_pkg::dp_cmd_t  cmd_reg;
    logic              ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cmd_reg.op   <= rvt_pkg::OP_NONE;
            cmd_reg.axis <= 2'd0;
            ready_reg    <= 1'b1;
        end
        else
        begin
            cmd_reg.op <= rvt_pkg::OP_NONE;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg    <= ST_PA;
                        cmd_reg.op   <= rvt_pkg::OP_PLANE_A;
                        cmd_reg.axis <= 2'd0;
                        ready_reg    <= 1'b0;
                    end
                end
                ST_PA:
                begin
                    if (status.dir_zero)
                    begin
                        state_reg  <= ST_PB;
                        cmd_reg.op <= rvt_pkg::OP_PLANE_B;
                    end
                    else
                    begin
                        state_reg  <= ST_DWA;
                        cmd_reg.op <= rvt_pkg::OP_DIV_T;
                    end
                end
                ST_DWA:
                begin
                    if (status.div_done)
                    begin
                        state_reg  <= ST_ST;
                        cmd_reg.op <= rvt_pkg::OP_STORE_TL;
                    end
                end
                ST_ST:
                begin
                    state_reg  <= ST_PB;
                    cmd_reg.op <= rvt_pkg::OP_PLANE_B;
                end
                ST_PB:
                begin
                    if (status.dir_zero)
                    begin
                        state_reg  <= ST_CU;
                        cmd_reg.op <= rvt_pkg::OP_CLIP;
                    end
                    else
                    begin
                        state_reg  <= ST_DWB;
                        cmd_reg.op <= rvt_pkg::OP_DIV_T;
                    end
                end
                ST_DWB:
                begin
                    if (status.div_done)
                    begin
                        state_reg  <= ST_CU;
                        cmd_reg.op <= rvt_pkg::OP_CLIP;
                    end
                end
                ST_CU:
                begin
                    if (cmd_reg.axis != 2'd2)
                    begin
                        state_reg    <= ST_PA;
                        cmd_reg.op   <= rvt_pkg::OP_PLANE_A;
                        cmd_reg.axis <= cmd_reg.axis + 2'd1;
                    end
                    else
                        state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    if (status.miss)
                    begin
                        state_reg  <= ST_WI;
                        cmd_reg.op <= rvt_pkg::OP_WALK_INIT;
                    end
                    else
                    begin
                        state_reg    <= ST_EM;
                        cmd_reg.op   <= rvt_pkg::OP_MUL;
                        cmd_reg.axis <= 2'd0;
                    end
                end
                ST_EM:
                begin
                    state_reg  <= ST_EE;
                    cmd_reg.op <= rvt_pkg::OP_ENT;
                end
                ST_EE:
                begin
                    state_reg  <= ST_DWC;
                    cmd_reg.op <= rvt_pkg::OP_DIV_CELL;
                end
                ST_DWC:
                begin
                    if (status.div_done)
                    begin
                        state_reg  <= ST_CL;
                        cmd_reg.op <= rvt_pkg::OP_CELL;
                    end
                end
                ST_CL:
                begin
                    if (status.dir_zero)
                    begin
                        state_reg  <= ST_AXE;
                        cmd_reg.op <= rvt_pkg::OP_ZERO;
                    end
                    else
                    begin
                        state_reg  <= ST_DWD;
                        cmd_reg.op <= rvt_pkg::OP_DIV_DELTA;
                    end
                end
                ST_DWD:
                begin
                    if (status.div_done)
                    begin
                        state_reg  <= ST_DL;
                        cmd_reg.op <= rvt_pkg::OP_DELTA;
                    end
                end
                ST_DL:
                begin
                    state_reg  <= ST_PN;
                    cmd_reg.op <= rvt_pkg::OP_PLANE_N;
                end
                ST_PN:
                begin
                    state_reg  <= ST_DWN;
                    cmd_reg.op <= rvt_pkg::OP_DIV_T;
                end
                ST_DWN:
                begin
                    if (status.div_done)
                    begin
                        state_reg  <= ST_AXE;
                        cmd_reg.op <= rvt_pkg::OP_NEXT;
                    end
                end
                ST_AXE:
                begin
                    if (cmd_reg.axis != 2'd2)
                    begin
                        state_reg    <= ST_EM;
                        cmd_reg.op   <= rvt_pkg::OP_MUL;
                        cmd_reg.axis <= cmd_reg.axis + 2'd1;
                    end
                    else
                    begin
                        state_reg  <= ST_WI;
                        cmd_reg.op <= rvt_pkg::OP_WALK_INIT;
                    end
                end
                ST_WI:
                begin
                    state_reg  <= ST_WK;
                    cmd_reg.op <= rvt_pkg::OP_WALK;
                end
                ST_WK:
                begin
                    if (status.walk_active)
                        cmd_reg.op <= rvt_pkg::OP_WALK;
                    else
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign cmd      = cmd_reg;
    assign in_ready = ready_reg;

endmodule
`default_nettype wire

[rtl/core/rvt_checker.sv]
`default_nettype none
module rvt_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    input  wire logic          s_axis_tready,
    input  wire logic          m_axis_tvalid,
    input  wire logic          m_axis_tready,
    input  wire logic [47:0]   m_axis_tdata,
    input  wire logic [0:0]    m_axis_tuser,
    input  wire logic          m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ray accepted while busy");

    a_miss_format: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 48'd0)
        else $error("malformed miss result");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_axis_tready) |-> $past(m_axis_tvalid) && $past(m_axis_tlast))
        else $error("ready before final result");

endmodule

bind ray_voxel_traversal_core rvt_checker u_rvt_checker (.*);
`default_nettype wire
